[rtl/ptst_pkg.sv]
// Package for the primality tester: widths, codes, state type and trial prime table.
`default_nettype none
package ptst_pkg;
   localparam int CAND_W        = 32;
   localparam int RND_W         = 32;
   localparam int ROUNDS_W      = 4;
   localparam int DEF_WIDTH     = 32;
   localparam int DEF_MAX_ROUNDS = 8;
   localparam int TABLE_SIZE    = 167;
   localparam int DEF_TRIAL     = 167;
   localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 4'd4;

   localparam logic [1:0] DEC_SMALL = 2'd0;
   localparam logic [1:0] DEC_TRIAL = 2'd1;
   localparam logic [1:0] DEC_MR    = 2'd2;

   localparam logic [9:0] TRIAL_TABLE [TABLE_SIZE] = '{
      10'd3,10'd5,10'd7,10'd11,10'd13,10'd17,10'd19,10'd23,10'd29,10'd31,10'd37,10'd41,
      10'd43,10'd47,10'd53,10'd59,10'd61,10'd67,10'd71,10'd73,10'd79,10'd83,10'd89,10'd97,
      10'd101,10'd103,10'd107,10'd109,10'd113,10'd127,10'd131,10'd137,10'd139,10'd149,
      10'd151,10'd157,10'd163,10'd167,10'd173,10'd179,10'd181,10'd191,10'd193,10'd197,
      10'd199,10'd211,10'd223,10'd227,10'd229,10'd233,10'd239,10'd241,10'd251,10'd257,
      10'd263,10'd269,10'd271,10'd277,10'd281,10'd283,10'd293,10'd307,10'd311,10'd313,
      10'd317,10'd331,10'd337,10'd347,10'd349,10'd353,10'd359,10'd367,10'd373,10'd379,
      10'd383,10'd389,10'd397,10'd401,10'd409,10'd419,10'd421,10'd431,10'd433,10'd439,
      10'd443,10'd449,10'd457,10'd461,10'd463,10'd467,10'd479,10'd487,10'd491,10'd499,
      10'd503,10'd509,10'd521,10'd523,10'd541,10'd547,10'd557,10'd563,10'd569,10'd571,
      10'd577,10'd587,10'd593,10'd599,10'd601,10'd607,10'd613,10'd617,10'd619,10'd631,
      10'd641,10'd643,10'd647,10'd653,10'd659,10'd661,10'd673,10'd677,10'd683,10'd691,
      10'd701,10'd709,10'd719,10'd727,10'd733,10'd739,10'd743,10'd751,10'd757,10'd761,
      10'd769,10'd773,10'd787,10'd797,10'd809,10'd811,10'd821,10'd823,10'd827,10'd829,
      10'd839,10'd853,10'd857,10'd859,10'd863,10'd877,10'd881,10'd883,10'd887,10'd907,
      10'd911,10'd919,10'd929,10'd937,10'd941,10'd947,10'd953,10'd967,10'd971,10'd977,
      10'd983,10'd991,10'd997
   };

   typedef enum logic [3:0] {
      S_IDLE, S_TRIAL, S_TWAIT, S_SPLIT, S_WIT, S_WWAIT, S_PCHK,
      S_PMWAIT, S_PSWAIT, S_ZCHK, S_ZWAIT, S_DONE
   } state_type;
endpackage
`default_nettype wire

[rtl/ptst_modmul.sv]
// Bit-serial modular multiplier: x * y mod m, one bit of y per cycle, MSB first.
`default_nettype none
module ptst_modmul #(
   parameter int W  = 32,
   parameter int YW = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [W-1:0]  x,
   input  wire logic [YW-1:0] y,
   input  wire logic [W-1:0]  m,
   output logic               done,
   output logic [W-1:0]       result
);
   localparam int CW = $clog2(YW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [YW-1:0] y_ff, y_in;
   logic [W-1:0]  x_ff, x_in, m_ff, m_in, acc_ff, acc_in;
   logic [W+1:0]  sum, t1, t2, mext;

   always_comb begin
      mext = (W+2)'(m_ff);
      sum  = {1'b0, acc_ff, 1'b0} + (y_ff[YW-1] ? (W+2)'(x_ff) : '0);
      t1   = (sum >= mext) ? sum - mext : sum;
      t2   = (t1 >= mext) ? t1 - mext : t1;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      y_in    = y_ff;
      x_in    = x_ff;
      m_in    = m_ff;
      acc_in  = acc_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = CW'(YW);
         y_in    = y;
         x_in    = x;
         m_in    = m;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = t2[W-1:0];
         y_in   = y_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      y_ff   <= y_in;
      x_ff   <= x_in;
      m_ff   <= m_in;
      acc_ff <= acc_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("modmul done while busy");
   assert property (@(posedge clock) disable iff (reset) done_ff |=> !done_ff)
      else $error("modmul done longer than one cycle");
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> acc_ff < m_ff)
      else $error("modmul partial result not reduced");
endmodule
`default_nettype wire

[rtl/primality_tester_top.sv]
// Top level of the primality tester: command port, sequencer and config register.
// For small or even candidates the result follows in the cycle after the accepting edge;
// otherwise one modular multiply per trial prime tried, then per Miller-Rabin round one for
// the witness plus up to two per exponent bit and one per squaring.
// One item at a time, busy until the result.
// Every multiply and reduction runs through one bit-serial unit, one bit per cycle.
// Synchronous active-high reset: idle, rounds register back to 4; no result is lost
// since the receiver cannot stall.
`default_nettype none
module primality_tester_top #(
   parameter int WIDTH        = ptst_pkg::DEF_WIDTH,
   parameter int MAX_ROUNDS   = ptst_pkg::DEF_MAX_ROUNDS,
   parameter int TRIAL_PRIMES = ptst_pkg::DEF_TRIAL
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [ptst_pkg::CAND_W-1:0]   req_candidate,
   input  wire logic [ptst_pkg::RND_W-1:0]    req_random_0,
   input  wire logic [ptst_pkg::RND_W-1:0]    req_random_1,
   input  wire logic [ptst_pkg::RND_W-1:0]    req_random_2,
   input  wire logic [ptst_pkg::RND_W-1:0]    req_random_3,
   input  wire logic [ptst_pkg::RND_W-1:0]    req_random_4,
   input  wire logic [ptst_pkg::RND_W-1:0]    req_random_5,
   input  wire logic [ptst_pkg::RND_W-1:0]    req_random_6,
   input  wire logic [ptst_pkg::RND_W-1:0]    req_random_7,
   output logic                               rsp_valid,
   output logic                               rsp_prime,
   output logic [1:0]                         rsp_decided_by,
   input  wire logic                          csr_we,
   input  wire logic [ptst_pkg::ROUNDS_W-1:0] csr_wdata
);
   import ptst_pkg::*;

   localparam int RW = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
   localparam int IW = (TRIAL_PRIMES > 1) ? $clog2(TRIAL_PRIMES) : 1;
   localparam int TW = $clog2(WIDTH) + 1;

   state_type state_ff, state_in;
   logic [ROUNDS_W-1:0] rounds_ff, count_ff, count_in;
   logic [WIDTH-1:0] n_ff, n_in, d_ff, d_in, e_ff, e_in, acc_ff, acc_in, b_ff, b_in;
   logic [RND_W-1:0] rnd_ff [MAX_ROUNDS];
   logic [RND_W-1:0] rnd_in [8];
   logic [RW-1:0]    r_ff, r_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [TW-1:0]    twos_ff, twos_in, j_ff, j_in;
   logic             prime_ff, prime_in;
   logic [1:0]       stage_ff, stage_in;

   logic             accept;
   logic [WIDTH-1:0] nin, nm1;
   logic [CAND_W-1:0] p_ext, n_ext;
   logic             last_idx, last_round;
   logic             mm_start, mm_done;
   logic [WIDTH-1:0] mm_x, mm_m, mm_res;
   logic [RND_W-1:0] mm_y;

   assign rnd_in[0] = req_random_0;
   assign rnd_in[1] = req_random_1;
   assign rnd_in[2] = req_random_2;
   assign rnd_in[3] = req_random_3;
   assign rnd_in[4] = req_random_4;
   assign rnd_in[5] = req_random_5;
   assign rnd_in[6] = req_random_6;
   assign rnd_in[7] = req_random_7;

   assign accept     = start && (state_ff == S_IDLE);
   assign nin        = req_candidate[WIDTH-1:0];
   assign nm1        = n_ff - 1'b1;
   assign p_ext      = CAND_W'(TRIAL_TABLE[8'(idx_ff)]);
   assign n_ext      = CAND_W'(n_ff);
   assign last_idx   = (idx_ff == IW'(TRIAL_PRIMES - 1));
   assign last_round = ((ROUNDS_W'(r_ff) + 1'b1) == count_ff);

   ptst_modmul #(.W(WIDTH), .YW(RND_W)) u_modmul (
      .clock  (clock),
      .reset  (reset),
      .start  (mm_start),
      .x      (mm_x),
      .y      (mm_y),
      .m      (mm_m),
      .done   (mm_done),
      .result (mm_res)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      n_in     = n_ff;
      d_in     = d_ff;
      e_in     = e_ff;
      acc_in   = acc_ff;
      b_in     = b_ff;
      r_in     = r_ff;
      idx_in   = idx_ff;
      twos_in  = twos_ff;
      j_in     = j_ff;
      prime_in = prime_ff;
      stage_in = stage_ff;
      mm_start = 1'b0;
      mm_x     = b_ff;
      mm_y     = RND_W'(b_ff);
      mm_m     = n_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               n_in     = nin;
               d_in     = nin - 1'b1;
               twos_in  = '0;
               idx_in   = '0;
               prime_in = 1'b0;
               stage_in = DEC_SMALL;
               if (rounds_ff == '0) begin
                  count_in = ROUNDS_W'(1);
               end else if (rounds_ff > ROUNDS_W'(MAX_ROUNDS)) begin
                  count_in = ROUNDS_W'(MAX_ROUNDS);
               end else begin
                  count_in = rounds_ff;
               end
               if (nin < WIDTH'(2)) begin
                  state_in = S_DONE;
               end else if (nin == WIDTH'(2)) begin
                  prime_in = 1'b1;
                  state_in = S_DONE;
               end else if (!nin[0]) begin
                  state_in = S_DONE;
               end else begin
                  stage_in = DEC_TRIAL;
                  state_in = S_TRIAL;
               end
            end
         end
         S_TRIAL: begin
            mm_x = WIDTH'(1);
            mm_y = RND_W'(n_ff);
            mm_m = p_ext[WIDTH-1:0];
            if (n_ext == p_ext) begin
               prime_in = 1'b1;
               state_in = S_DONE;
            end else if (p_ext > n_ext) begin
               if (last_idx) begin
                  stage_in = DEC_MR;
                  state_in = S_SPLIT;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               mm_start = 1'b1;
               state_in = S_TWAIT;
            end
         end
         S_TWAIT: begin
            if (mm_done) begin
               if (mm_res == '0) begin
                  state_in = S_DONE;
               end else if (last_idx) begin
                  stage_in = DEC_MR;
                  state_in = S_SPLIT;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_TRIAL;
               end
            end
         end
         S_SPLIT: begin
            r_in = '0;
            if (!d_ff[0]) begin
               d_in    = d_ff >> 1;
               twos_in = twos_ff + 1'b1;
            end else begin
               state_in = S_WIT;
            end
         end
         S_WIT: begin
            mm_x     = WIDTH'(1);
            mm_y     = rnd_ff[r_ff];
            mm_m     = n_ff - WIDTH'(3);
            mm_start = 1'b1;
            state_in = S_WWAIT;
         end
         S_WWAIT: begin
            if (mm_done) begin
               b_in     = mm_res + WIDTH'(2);
               acc_in   = WIDTH'(1);
               e_in     = d_ff;
               state_in = S_PCHK;
            end
         end
         S_PCHK: begin
            if (e_ff == '0) begin
               j_in = '0;
               if (acc_ff == WIDTH'(1) || acc_ff == nm1) begin
                  if (last_round) begin
                     prime_in = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     r_in     = r_ff + 1'b1;
                     state_in = S_WIT;
                  end
               end else begin
                  state_in = S_ZCHK;
               end
            end else if (e_ff[0]) begin
               mm_x     = acc_ff;
               mm_start = 1'b1;
               state_in = S_PMWAIT;
            end else begin
               mm_start = 1'b1;
               state_in = S_PSWAIT;
            end
         end
         S_PMWAIT: begin
            if (mm_done) begin
               acc_in   = mm_res;
               mm_start = 1'b1;
               state_in = S_PSWAIT;
            end
         end
         S_PSWAIT: begin
            if (mm_done) begin
               b_in     = mm_res;
               e_in     = e_ff >> 1;
               state_in = S_PCHK;
            end
         end
         S_ZCHK: begin
            mm_x = acc_ff;
            mm_y = RND_W'(acc_ff);
            if (acc_ff == nm1) begin
               if (last_round) begin
                  prime_in = 1'b1;
                  state_in = S_DONE;
               end else begin
                  r_in     = r_ff + 1'b1;
                  state_in = S_WIT;
               end
            end else if ((j_ff + 1'b1) < twos_ff) begin
               mm_start = 1'b1;
               state_in = S_ZWAIT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_ZWAIT: begin
            if (mm_done) begin
               acc_in = mm_res;
               j_in   = j_ff + 1'b1;
               state_in = (mm_res == WIDTH'(1)) ? S_DONE : S_ZCHK;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rounds_ff <= ROUNDS_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            rounds_ff <= csr_wdata;
         end
      end
      count_ff <= count_in;
      n_ff     <= n_in;
      d_ff     <= d_in;
      e_ff     <= e_in;
      acc_ff   <= acc_in;
      b_ff     <= b_in;
      r_ff     <= r_in;
      idx_ff   <= idx_in;
      twos_ff  <= twos_in;
      j_ff     <= j_in;
      prime_ff <= prime_in;
      stage_ff <= stage_in;
      if (accept) begin
         for (int i = 0; i < MAX_ROUNDS; i++) begin
            rnd_ff[i] <= rnd_in[i];
         end
      end
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = (state_ff == S_DONE);
   assign rsp_prime      = prime_ff;
   assign rsp_decided_by = stage_ff;

   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !busy)
      else $error("busy after result beat");
   assert property (@(posedge clock) disable iff (reset) accept |=> busy)
      else $error("not busy after accepted beat");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (stage_ff == DEC_SMALL || stage_ff == DEC_TRIAL || stage_ff == DEC_MR))
      else $error("bad decided_by code");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && stage_ff != DEC_SMALL) |-> n_ff[0])
      else $error("even candidate past small checks");
endmodule
`default_nettype wire
